// ----- rtl/dbd_pkg.sv -----
package dbd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned ACC_W   = 25;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [YEAR_W-1:0]  ERA_YEARS  = 14'd400;
    localparam logic [ACC_W-1:0]   ERA_DAYS   = 25'd146097;
    localparam logic [ACC_W-1:0]   YEAR_DAYS  = 25'd365;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd4194303;

    // Reciprocal of 100 scaled by 2**19, exact for every 14-bit year.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                            r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:         r = 5'd30;
            default:                         r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        if (m < MONTH_JAN)
            r = MONTH_JAN;
        else if (m > MONTH_DEC)
            r = MONTH_DEC;
        else
            r = m;
        return r;
    endfunction

    // Day of the year, with the day first clamped into the month.
    function automatic logic [DOY_W-1:0] day_of_year(input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0] d,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        logic [DAY_W-1:0] dc;
        logic [DOY_W-1:0] r;
        len = month_length(m, leap);
        if (d == '0)
            dc = 5'd1;
        else if (d > len)
            dc = len;
        else
            dc = d;
        r = days_before(m) + {{(DOY_W-DAY_W){1'b0}}, dc};
        if (m > MONTH_FEB && leap)
            r = r + 9'd1;
        return r;
    endfunction

endpackage

// ----- rtl/days_between_dates_counter.sv -----
// Channel  Direction  Handshake              Words
// in       input      in_valid / in_stall    two dates and include_today
// out      output     out_valid / out_stall  day_count
//
// A word is worked through the start date, the end date, then each year between
// the two dates in turn, with whole 400-year spans stepped as one.
// The pace is set by the single leap-year unit, whose registered answer the
// sequencer waits for after each new year. Reset clears the sequencer and the
// output valid. A new word is taken while a finished result waits on out_stall.
module days_between_dates_counter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dbd_pkg::YEAR_W-1:0]      start_year,
    input  logic [dbd_pkg::MONTH_W-1:0]     start_month,
    input  logic [dbd_pkg::DAY_W-1:0]       start_day,
    input  logic [dbd_pkg::YEAR_W-1:0]      end_year,
    input  logic [dbd_pkg::MONTH_W-1:0]     end_month,
    input  logic [dbd_pkg::DAY_W-1:0]       end_day,
    input  logic                            include_today,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dbd_pkg::COUNT_W-1:0]     day_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_START,
        ST_START,
        ST_WAIT_END,
        ST_END,
        ST_WAIT_YEAR,
        ST_YEAR,
        ST_DONE
    } state_t;

    localparam int unsigned AW = dbd_pkg::ACC_W;
    localparam int unsigned CW = dbd_pkg::COUNT_W;

    state_t                          state_reg, state_next;
    logic [dbd_pkg::YEAR_W-1:0]      y_reg, y_next;
    logic [dbd_pkg::YEAR_W-1:0]      sy_reg, sy_next;
    logic [dbd_pkg::MONTH_W-1:0]     sm_reg, sm_next;
    logic [dbd_pkg::DAY_W-1:0]       sd_reg, sd_next;
    logic [dbd_pkg::YEAR_W-1:0]      ey_reg, ey_next;
    logic [dbd_pkg::MONTH_W-1:0]     em_reg, em_next;
    logic [dbd_pkg::DAY_W-1:0]       ed_reg, ed_next;
    logic                            inc_reg, inc_next;
    logic [AW-1:0]                   acc_reg, acc_next;
    logic                            out_valid_reg, out_valid_next;
    logic [CW-1:0]                   day_count_reg, day_count_next;

    logic                            leap;
    logic [dbd_pkg::DOY_W-1:0]       doy;
    logic [AW-1:0]                   doy_ext;
    logic [dbd_pkg::YEAR_W-1:0]      years_left;
    logic [CW:0]                     sum;
    logic                            out_free;

    dbd_leap_unit u_leap (
        .clk  (clk),
        .year (y_reg),
        .leap (leap)
    );

    always_comb
    begin
        if (state_reg == ST_START)
            doy = dbd_pkg::day_of_year(sm_reg, sd_reg, leap);
        else
            doy = dbd_pkg::day_of_year(em_reg, ed_reg, leap);
        doy_ext    = {{(AW-dbd_pkg::DOY_W){1'b0}}, doy};
        years_left = ey_reg - y_reg;
        sum        = acc_reg[CW:0] + {{CW{1'b0}}, inc_reg};
        out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        y_next         = y_reg;
        sy_next        = sy_reg;
        sm_next        = sm_reg;
        sd_next        = sd_reg;
        ey_next        = ey_reg;
        em_next        = em_reg;
        ed_next        = ed_reg;
        inc_next       = inc_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        day_count_next = day_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sy_next    = start_year;
                    sm_next    = dbd_pkg::clamp_month(start_month);
                    sd_next    = start_day;
                    ey_next    = end_year;
                    em_next    = dbd_pkg::clamp_month(end_month);
                    ed_next    = end_day;
                    inc_next   = include_today;
                    y_next     = start_year;
                    state_next = ST_WAIT_START;
                end
            end
            ST_WAIT_START:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                acc_next   = '0 - doy_ext;
                y_next     = ey_reg;
                state_next = ST_WAIT_END;
            end
            ST_WAIT_END:
            begin
                state_next = ST_END;
            end
            ST_END:
            begin
                acc_next = acc_reg + doy_ext;
                y_next   = sy_reg;
                if (sy_reg < ey_reg)
                    state_next = ST_WAIT_YEAR;
                else
                    state_next = ST_DONE;
            end
            ST_WAIT_YEAR:
            begin
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (years_left >= dbd_pkg::ERA_YEARS)
                begin
                    acc_next = acc_reg + dbd_pkg::ERA_DAYS;
                    y_next   = y_reg + dbd_pkg::ERA_YEARS;
                end
                else
                begin
                    acc_next = acc_reg + dbd_pkg::YEAR_DAYS + {{(AW-1){1'b0}}, leap};
                    y_next   = y_reg + 14'd1;
                end
                if (y_next == ey_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_WAIT_YEAR;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sy_reg > ey_reg || acc_reg[AW-1] || acc_reg == '0)
                        day_count_next = {{(CW-1){1'b0}}, inc_reg};
                    else if (acc_reg[AW-2:CW] != '0 || sum[CW])
                        day_count_next = dbd_pkg::COUNT_MAX;
                    else
                        day_count_next = sum[CW-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        sy_reg        <= sy_next;
        sm_reg        <= sm_next;
        sd_reg        <= sd_next;
        ey_reg        <= ey_next;
        em_reg        <= em_next;
        ed_reg        <= ed_next;
        inc_reg       <= inc_next;
        acc_reg       <= acc_next;
        day_count_reg <= day_count_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign day_count = day_count_reg;

endmodule

// ----- rtl/dbd_leap_unit.sv -----
module dbd_leap_unit (
    input  logic                          clk,
    input  logic [dbd_pkg::YEAR_W-1:0]    year,
    output logic                          leap
);

    logic [26:0]                   prod;
    logic [7:0]                    cent;
    logic [dbd_pkg::YEAR_W-1:0]    cent_x100;
    logic [dbd_pkg::YEAR_W-1:0]    rem;
    logic                          leap_next;
    logic                          leap_reg;

    always_comb
    begin
        prod      = 27'(year) * 27'(dbd_pkg::RECIP_100);
        cent      = prod[dbd_pkg::RECIP_SHIFT +: 8];
        cent_x100 = ({6'b0, cent} << 6) + ({6'b0, cent} << 5) + ({6'b0, cent} << 2);
        rem       = year - cent_x100;
        leap_next = (year[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
    end

    always_ff @(posedge clk)
    begin
        leap_reg <= leap_next;
    end

    assign leap = leap_reg;

endmodule

// ----- test/tb_days_between_dates_counter.sv -----
module tb_days_between_dates_counter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 1000;
    localparam int unsigned RANDOM_WORDS = 116;

    typedef struct {
        logic [dbd_pkg::YEAR_W-1:0]  start_year;
        logic [dbd_pkg::MONTH_W-1:0] start_month;
        logic [dbd_pkg::DAY_W-1:0]   start_day;
        logic [dbd_pkg::YEAR_W-1:0]  end_year;
        logic [dbd_pkg::MONTH_W-1:0] end_month;
        logic [dbd_pkg::DAY_W-1:0]   end_day;
        logic                        include_today;
    } date_word_t;

    localparam int unsigned DAYS_AHEAD[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                                273, 304, 334};

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [dbd_pkg::YEAR_W-1:0]    start_year = '0;
    logic [dbd_pkg::MONTH_W-1:0]   start_month = '0;
    logic [dbd_pkg::DAY_W-1:0]     start_day = '0;
    logic [dbd_pkg::YEAR_W-1:0]    end_year = '0;
    logic [dbd_pkg::MONTH_W-1:0]   end_month = '0;
    logic [dbd_pkg::DAY_W-1:0]     end_day = '0;
    logic                          include_today = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [dbd_pkg::COUNT_W-1:0]   day_count;

    date_word_t                    pending_words[$];
    date_word_t                    shown_word;
    logic [dbd_pkg::COUNT_W-1:0]   expected_counts[$];
    int unsigned                   gap_left;
    int unsigned                   burst_left;
    int unsigned                   stall_pct;
    int unsigned                   stall_cycle;
    int unsigned                   idle_cycles;
    int unsigned                   words_sent;
    int unsigned                   counts_checked;
    int unsigned                   zero_counts;
    int unsigned                   saturated_counts;
    int unsigned                   mismatches;

    days_between_dates_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .include_today (include_today),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .day_count     (day_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit is_leap(int unsigned y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        int unsigned n;
        case (m)
            2:          n = is_leap(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:    n = 31;
        endcase
        return n;
    endfunction

    // Serial day number with the year moved up by 400 so year zero needs no special case.
    function automatic int unsigned day_number(int unsigned y, int unsigned m_raw,
                                               int unsigned d_raw);
        int unsigned m;
        int unsigned d;
        int unsigned yy;
        int unsigned n;
        m = (m_raw < 1) ? 1 : (m_raw > 12) ? 12 : m_raw;
        d = (d_raw < 1) ? 1 : (d_raw > month_days(m, y)) ? month_days(m, y) : d_raw;
        yy = y + 400;
        n = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400
            + DAYS_AHEAD[m - 1] + d;
        if (m > 2 && is_leap(y))
            n = n + 1;
        return n;
    endfunction

    function automatic logic [dbd_pkg::COUNT_W-1:0] days_between(date_word_t w);
        int unsigned a;
        int unsigned b;
        int unsigned n;
        a = day_number(w.start_year, w.start_month, w.start_day);
        b = day_number(w.end_year, w.end_month, w.end_day);
        n = (a < b) ? b - a : 0;
        n = n + w.include_today;
        if (n > dbd_pkg::COUNT_MAX)
            n = dbd_pkg::COUNT_MAX;
        return n[dbd_pkg::COUNT_W-1:0];
    endfunction

    function automatic date_word_t dates(int unsigned sy, int unsigned sm, int unsigned sd,
                                         int unsigned ey, int unsigned em, int unsigned ed,
                                         int unsigned inc);
        date_word_t w;
        w.start_year    = sy[dbd_pkg::YEAR_W-1:0];
        w.start_month   = sm[dbd_pkg::MONTH_W-1:0];
        w.start_day     = sd[dbd_pkg::DAY_W-1:0];
        w.end_year      = ey[dbd_pkg::YEAR_W-1:0];
        w.end_month     = em[dbd_pkg::MONTH_W-1:0];
        w.end_day       = ed[dbd_pkg::DAY_W-1:0];
        w.include_today = inc[0];
        return w;
    endfunction

    // Mostly well-formed date pairs at varied distances, some reversed, some raw noise.
    function automatic date_word_t random_dates();
        int unsigned kind;
        int unsigned sy;
        int unsigned sm;
        int unsigned sd;
        int unsigned ey;
        int unsigned em;
        int unsigned ed;
        int unsigned span;
        date_word_t w;
        kind = $urandom_range(0, 99);
        sy = $urandom_range(1, 9999);
        sm = $urandom_range(1, 12);
        sd = $urandom_range(1, month_days(sm, sy));
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = $urandom_range(0, 3);
            2:       span = $urandom_range(0, 60);
            default: span = $urandom_range(0, 9999 - sy);
        endcase
        if (sy + span > 9999)
            span = 9999 - sy;
        ey = sy + span;
        em = $urandom_range(1, 12);
        ed = $urandom_range(1, month_days(em, ey));
        if (kind >= 75 && kind < 88)
        begin
            ey = sy;
            em = sm;
            ed = $urandom_range(1, month_days(sm, sy));
        end
        if (kind >= 60 && kind < 75)
            w = dates(ey, em, ed, sy, sm, sd, $urandom_range(0, 1));
        else
            w = dates(sy, sm, sd, ey, em, ed, $urandom_range(0, 1));
        if (kind >= 88)
            w = dates($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                expected_counts.push_back(days_between(shown_word));
                words_sent++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                shown_word = pending_words.pop_front();
                start_year <= shown_word.start_year;
                start_month <= shown_word.start_month;
                start_day <= shown_word.start_day;
                end_year <= shown_word.end_year;
                end_month <= shown_word.end_month;
                end_day <= shown_word.end_day;
                include_today <= shown_word.include_today;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 7);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_pct <= 0;
            stall_cycle <= 0;
        end
        else
        begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 300 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 30;
                    2:       stall_pct <= 70;
                    default: stall_pct <= 95;
                endcase
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("day_count: expected nothing, got %0d", day_count);
                mismatches++;
            end
            else
            begin
                if (day_count !== expected_counts[0])
                begin
                    $error("day_count: expected %0d, got %0d", expected_counts[0], day_count);
                    mismatches++;
                end
                if (expected_counts[0] == 0)
                    zero_counts++;
                if (expected_counts[0] == dbd_pkg::COUNT_MAX)
                    saturated_counts++;
                void'(expected_counts.pop_front());
                counts_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_days_between_dates_counter: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        words_sent = 0;
        counts_checked = 0;
        zero_counts = 0;
        saturated_counts = 0;
        mismatches = 0;

        pending_words.push_back(dates(2024, 6, 15, 2024, 6, 15, 0));
        pending_words.push_back(dates(2024, 6, 15, 2024, 6, 15, 1));
        pending_words.push_back(dates(2024, 1, 1, 2024, 1, 2, 0));
        pending_words.push_back(dates(2024, 2, 28, 2024, 3, 1, 0));
        pending_words.push_back(dates(2023, 2, 28, 2023, 3, 1, 1));
        pending_words.push_back(dates(1900, 2, 28, 1900, 3, 1, 0));
        pending_words.push_back(dates(2000, 2, 28, 2000, 3, 1, 0));
        pending_words.push_back(dates(2023, 12, 31, 2024, 1, 1, 0));
        pending_words.push_back(dates(2024, 5, 10, 2024, 5, 9, 0));
        pending_words.push_back(dates(2024, 5, 10, 2024, 5, 9, 1));
        pending_words.push_back(dates(2025, 1, 1, 2024, 12, 31, 0));
        pending_words.push_back(dates(2024, 3, 1, 2024, 2, 29, 1));
        pending_words.push_back(dates(2020, 0, 0, 2020, 1, 1, 1));
        pending_words.push_back(dates(2021, 13, 31, 2021, 14, 5, 0));
        pending_words.push_back(dates(2021, 11, 30, 2021, 15, 31, 0));
        pending_words.push_back(dates(2023, 4, 31, 2023, 5, 1, 0));
        pending_words.push_back(dates(2024, 2, 30, 2024, 3, 1, 0));
        pending_words.push_back(dates(2023, 2, 31, 2023, 3, 1, 1));
        pending_words.push_back(dates(0, 1, 1, 1, 1, 1, 0));
        pending_words.push_back(dates(0, 2, 29, 0, 3, 1, 0));
        pending_words.push_back(dates(1, 1, 1, 9999, 12, 31, 1));
        pending_words.push_back(dates(9999, 12, 31, 16383, 15, 31, 0));
        pending_words.push_back(dates(0, 0, 0, 16383, 15, 31, 1));
        pending_words.push_back(dates(16383, 15, 31, 0, 0, 0, 1));
        for (int i = 0; i < RANDOM_WORDS; i++)
            pending_words.push_back(random_dates());

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || in_valid || expected_counts.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d date words and checked %0d day counts.", words_sent, counts_checked);
        $display("Of those, %0d counts were zero and %0d saturated.",
                 zero_counts, saturated_counts);
        if (mismatches == 0)
            $display("tb_days_between_dates_counter: PASS");
        else
            $display("tb_days_between_dates_counter: FAIL");
        $finish;
    end

endmodule
